// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/depq_pkg.sv
// ----------------------------------------------------------------------------
// depq_pkg
// Types and constants of the double-ended priority queue.
// ----------------------------------------------------------------------------
package depq_pkg;

    localparam int CAPACITY = 1024;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = 11;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DEL_MAX = 2'd1,
        OP_DEL_MIN = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_SHIFT,
        S_FIX,
        S_OUT
    } t_state;

endpackage

// File: src/depq_if.sv
// ----------------------------------------------------------------------------
// depq_in_if / depq_out_if
// Valid/ready channels of the queue.
// ----------------------------------------------------------------------------
interface depq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic signed [31:0] value;
    modport source (output valid, func, value, input ready);
    modport sink   (input valid, func, value, output ready);
endinterface

interface depq_out_if;
    logic        valid;
    logic        ready;
    logic        is_empty;
    logic [10:0] entry_count;
    logic signed [31:0] max_value;
    logic signed [31:0] min_value;
    logic [1:0]  status;
    modport source (output valid, is_empty, entry_count, max_value, min_value, status,
                    input ready);
    modport sink   (input valid, is_empty, entry_count, max_value, min_value, status,
                    output ready);
endinterface

// File: src/depq_ram.sv
// ----------------------------------------------------------------------------
// depq_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module depq_ram #(
    parameter int DEPTH = depq_pkg::CAPACITY,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [31:0]   i_wdata,
    output logic [31:0]   o_rdata
);
    logic [31:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: src/double_ended_priority_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_priority_queue_core
// Sorted multiset of signed values held in one RAM; reports count, max, min.
// ----------------------------------------------------------------------------
// Values are kept in ascending order in a single-port RAM, ends cached in
// registers. Clear, a delete on zero or one entry and any rejected operation
// go straight to the result. Delete-max does one RAM read for the new
// maximum. Insert walks down from the top, one entry per step (read, then
// write one slot up), and places the value on top without a walk when it is
// not below the maximum. Delete-min shifts every entry down one slot. One
// item is processed at a time; the result sits in an output register until
// taken.
module double_ended_priority_queue_core #(
    parameter int CAPACITY = depq_pkg::CAPACITY
) (
    input  logic i_clk,
    input  logic i_rst_n,
    depq_in_if.sink    i_in,
    depq_out_if.source o_out
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int NW = $clog2(CAPACITY + 1);

    depq_pkg::t_state r_state, n_state;
    logic [NW-1:0] r_cnt, n_cnt;
    logic [NW-1:0] r_pos, n_pos;
    logic [31:0]   r_key, n_key;
    logic [1:0]    r_op, n_op;
    logic [31:0]   r_min, n_min, r_max, n_max;
    depq_pkg::t_status r_st, n_st;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_wdata, ram_rdata;

    depq_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= depq_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_pos <= n_pos;
        r_key <= n_key;
        r_op  <= n_op;
        r_min <= n_min;
        r_max <= n_max;
        r_st  <= n_st;
    end

    // next state and datapath
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_pos = r_pos;
        n_key = r_key;
        n_op = r_op;
        n_min = r_min;
        n_max = r_max;
        n_st = r_st;
        unique case (r_state)
            depq_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_op  = i_in.func;
                    n_key = i_in.value ^ 32'h8000_0000;
                    n_st  = depq_pkg::ST_DONE;
                    n_state = depq_pkg::S_OUT;
                    unique case (depq_pkg::t_op'(i_in.func))
                        depq_pkg::OP_INSERT: begin
                            if (r_cnt >= NW'(CAPACITY)) begin
                                n_st = depq_pkg::ST_FULL;
                            end else begin
                                n_pos = r_cnt;
                                n_state = depq_pkg::S_RD;
                            end
                        end
                        depq_pkg::OP_DEL_MAX: begin
                            if (r_cnt == '0) begin
                                n_st = depq_pkg::ST_EMPTY;
                            end else if (r_cnt == NW'(1)) begin
                                n_cnt = '0;
                            end else begin
                                n_cnt = r_cnt - NW'(1);
                                n_pos = r_cnt - NW'(2);
                                n_state = depq_pkg::S_FIX;
                            end
                        end
                        depq_pkg::OP_DEL_MIN: begin
                            if (r_cnt == '0) begin
                                n_st = depq_pkg::ST_EMPTY;
                            end else if (r_cnt == NW'(1)) begin
                                n_cnt = '0;
                            end else begin
                                n_pos = NW'(1);
                                n_state = depq_pkg::S_CMP;
                            end
                        end
                        depq_pkg::OP_CLEAR: n_cnt = '0;
                    endcase
                end
            end
            depq_pkg::S_RD: begin
                // insert: read below r_pos, or place key
                if (r_pos == '0 || r_key >= r_max) begin
                    n_state = depq_pkg::S_SHIFT;
                end else begin
                    n_state = depq_pkg::S_CMP;
                end
            end
            depq_pkg::S_CMP: begin
                if (r_op == depq_pkg::OP_INSERT) begin
                    if (ram_rdata > r_key) begin
                        n_pos = r_pos - NW'(1);
                        n_state = (r_pos == NW'(1)) ? depq_pkg::S_SHIFT : depq_pkg::S_RD;
                    end else begin
                        n_state = depq_pkg::S_SHIFT;
                    end
                end else begin
                    // delete-min: read r_pos, moved down next cycle
                    n_state = depq_pkg::S_SHIFT;
                end
            end
            depq_pkg::S_SHIFT: begin
                if (r_op == depq_pkg::OP_INSERT) begin
                    if (r_pos == '0 || r_cnt == '0 || r_key < r_min) n_min = r_key;
                    if (r_pos == r_cnt) n_max = r_key;
                    n_cnt = r_cnt + NW'(1);
                    n_state = depq_pkg::S_OUT;
                end else begin
                    if (r_pos == NW'(1)) n_min = ram_rdata;
                    if (r_pos == r_cnt - NW'(1)) begin
                        n_cnt = r_cnt - NW'(1);
                        n_state = depq_pkg::S_OUT;
                    end else begin
                        n_pos = r_pos + NW'(1);
                        n_state = depq_pkg::S_CMP;
                    end
                end
            end
            depq_pkg::S_FIX: begin
                n_state = depq_pkg::S_OUT;
            end
            depq_pkg::S_OUT: begin
                if (o_out.ready) n_state = depq_pkg::S_IDLE;
            end
            default: n_state = depq_pkg::S_IDLE;
        endcase
        if (r_state == depq_pkg::S_FIX) n_max = ram_rdata;
        if (r_state == depq_pkg::S_IDLE && i_in.valid && r_cnt == '0
            && i_in.func == depq_pkg::OP_INSERT) begin
            n_min = i_in.value ^ 32'h8000_0000;
            n_max = i_in.value ^ 32'h8000_0000;
        end
    end

    // memory control (insert walks with a compare read each step)
    always_comb begin
        ram_we = 1'b0;
        ram_wdata = r_key;
        ram_addr = AW'(r_pos);
        unique case (r_state)
            depq_pkg::S_IDLE: ram_addr = AW'(r_cnt - NW'(2));
            depq_pkg::S_RD: ram_addr = AW'(r_pos - NW'(1));
            depq_pkg::S_CMP: begin
                if (r_op == depq_pkg::OP_INSERT && ram_rdata > r_key) begin
                    ram_we = 1'b1;
                    ram_wdata = ram_rdata;
                    ram_addr = AW'(r_pos);
                end else begin
                    ram_addr = AW'(r_pos);
                end
            end
            depq_pkg::S_SHIFT: begin
                if (r_op == depq_pkg::OP_INSERT) begin
                    ram_we = 1'b1;
                    ram_addr = AW'(r_pos);
                end else begin
                    ram_we = 1'b1;
                    ram_wdata = ram_rdata;
                    ram_addr = AW'(r_pos - NW'(1));
                end
            end
            default: ram_addr = AW'(r_pos);
        endcase
    end

    assign i_in.ready = (r_state == depq_pkg::S_IDLE);
    assign o_out.valid = (r_state == depq_pkg::S_OUT);
    assign o_out.is_empty = (r_cnt == '0);
    assign o_out.entry_count = 11'(r_cnt);
    assign o_out.max_value = (r_cnt == '0) ? '0 : (r_max ^ 32'h8000_0000);
    assign o_out.min_value = (r_cnt == '0) ? '0 : (r_min ^ 32'h8000_0000);
    assign o_out.status = r_st;
endmodule

// File: src/depq_checker.sv
// ----------------------------------------------------------------------------
// depq_checker
// Port-level checks of the queue, bound to the queue core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module depq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        is_empty,
    input logic [10:0] entry_count,
    input logic [1:0]  status
);
    `CHK_IMPL(a_empty_cnt, i_clk, i_rst_n, out_valid, is_empty == (entry_count == 11'd0), "empty flag mismatch")
    `CHK_IMPL(a_no_overlap, i_clk, i_rst_n, out_valid, !in_ready, "input taken while result pending")
    `CHK_IMPL(a_status_code, i_clk, i_rst_n, out_valid, status != depq_pkg::ST_RSVD, "bad status")
    `CHK_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(entry_count), "result dropped")
endmodule

bind double_ended_priority_queue_core depq_checker u_depq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_in.valid), .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready),
    .is_empty(o_out.is_empty), .entry_count(o_out.entry_count),
    .status(o_out.status)
);

// File: sim/double_ended_priority_queue_core_tb.sv
// ----------------------------------------------------------------------------
// double_ended_priority_queue_core_tb
// Drives random and directed insert/delete/clear items into the queue and
// compares every result against a sorted-array model of the held multiset.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module double_ended_priority_queue_core_tb;

    typedef struct packed {
        depq_pkg::t_op func;
        logic [31:0]   value;
    } t_item;

    typedef struct packed {
        logic        is_empty;
        logic [10:0] entry_count;
        logic [31:0] max_value;
        logic [31:0] min_value;
        logic [1:0]  status;
    } t_report;

    logic i_clk;
    logic i_rst_n;

    depq_in_if  in_ch();
    depq_out_if out_ch();

    double_ended_priority_queue_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    t_item       pending_items[$];
    t_report     expected_reports[$];
    logic signed [31:0] held_vals[$];
    int          error_count = 0;
    int          hold_cycles = 0;
    bit          pause_for_drain = 0;
    bit          in_taken = 0;
    int          send_gap = 0;
    int          recv_gap = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_report apply_op(t_item it);
        t_report r;
        int pos;
        r.status = depq_pkg::ST_DONE;
        case (it.func)
            depq_pkg::OP_INSERT: begin
                if (held_vals.size() >= depq_pkg::CAPACITY) begin
                    r.status = depq_pkg::ST_FULL;
                end else begin
                    pos = held_vals.size();
                    while (pos > 0 && held_vals[pos-1] > $signed(it.value)) pos--;
                    held_vals.insert(pos, $signed(it.value));
                end
            end
            depq_pkg::OP_DEL_MAX: begin
                if (held_vals.size() == 0) r.status = depq_pkg::ST_EMPTY;
                else void'(held_vals.pop_back());
            end
            depq_pkg::OP_DEL_MIN: begin
                if (held_vals.size() == 0) r.status = depq_pkg::ST_EMPTY;
                else void'(held_vals.pop_front());
            end
            default: held_vals.delete();
        endcase
        r.is_empty    = (held_vals.size() == 0);
        r.entry_count = 11'(held_vals.size());
        r.max_value   = r.is_empty ? 32'd0 : held_vals[held_vals.size()-1];
        r.min_value   = r.is_empty ? 32'd0 : held_vals[0];
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_value();
        int p;
        p = $urandom_range(0, 9);
        if (p < 2) return 32'h8000_0000 + $urandom_range(0, 3);
        if (p < 4) return 32'h7FFF_FFFC + $urandom_range(0, 3);
        if (p < 6) return $urandom_range(0, 15) - 8;
        return $urandom;
    endfunction

    task automatic add_item(depq_pkg::t_op f, logic [31:0] v);
        t_item it;
        it.func  = f;
        it.value = v;
        pending_items.push_back(it);
    endtask

    // sender: drive at falling edge, accept on rising edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_taken) begin
        end else begin
            in_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (pause_for_drain || pending_items.size() == 0) begin
                in_ch.valid <= 1'b0;
            end else begin
                in_ch.func  <= pending_items[0].func;
                in_ch.value <= pending_items[0].value;
                in_ch.valid <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready && !in_taken) begin
            expected_reports.push_back(apply_op(pending_items.pop_front()));
            send_gap = pick_gap();
            in_taken = 1'b1;
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles  = hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap     = recv_gap - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_report got, exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.is_empty, out_ch.entry_count, out_ch.max_value,
                   out_ch.min_value, out_ch.status};
            recv_gap = pick_gap();
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end else begin
                exp_r = expected_reports.pop_front();
                if (got.is_empty !== exp_r.is_empty) begin
                    $display("%0t: is_empty exp %0b got %0b", $time,
                             exp_r.is_empty, got.is_empty);
                    error_count++;
                end
                if (got.entry_count !== exp_r.entry_count) begin
                    $display("%0t: entry_count exp %0d got %0d", $time,
                             exp_r.entry_count, got.entry_count);
                    error_count++;
                end
                if (got.max_value !== exp_r.max_value) begin
                    $display("%0t: max_value exp %0d got %0d", $time,
                             $signed(exp_r.max_value), $signed(got.max_value));
                    error_count++;
                end
                if (got.min_value !== exp_r.min_value) begin
                    $display("%0t: min_value exp %0d got %0d", $time,
                             $signed(exp_r.min_value), $signed(got.min_value));
                    error_count++;
                end
                if (got.status !== exp_r.status) begin
                    $display("%0t: status exp %0d got %0d", $time,
                             exp_r.status, got.status);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #200_000_000;
        $display("double_ended_priority_queue_core_tb: errors");
        $finish;
    end

    initial begin
        int n, sel;
        in_ch.valid  = 1'b0;
        in_ch.func   = depq_pkg::OP_CLEAR;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;
        i_rst_n      = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty deletes, extremes, duplicates, clear
        add_item(depq_pkg::OP_DEL_MAX, 32'hFFFF_FFFF);
        add_item(depq_pkg::OP_DEL_MIN, 32'h0);
        add_item(depq_pkg::OP_CLEAR, 32'h5555_5555);
        add_item(depq_pkg::OP_INSERT, 32'h8000_0000);
        add_item(depq_pkg::OP_INSERT, 32'h7FFF_FFFF);
        add_item(depq_pkg::OP_INSERT, 32'h0);
        add_item(depq_pkg::OP_INSERT, 32'hFFFF_FFFF);
        add_item(depq_pkg::OP_INSERT, 32'h7FFF_FFFF);
        add_item(depq_pkg::OP_INSERT, 32'h1);
        add_item(depq_pkg::OP_DEL_MAX, 32'h0);
        add_item(depq_pkg::OP_DEL_MIN, 32'h0);
        add_item(depq_pkg::OP_DEL_MAX, 32'h0);
        add_item(depq_pkg::OP_DEL_MIN, 32'h0);
        add_item(depq_pkg::OP_DEL_MIN, 32'h0);
        add_item(depq_pkg::OP_DEL_MAX, 32'h0);
        add_item(depq_pkg::OP_DEL_MAX, 32'h0);
        add_item(depq_pkg::OP_INSERT, 32'hAAAA_AAAA);
        add_item(depq_pkg::OP_INSERT, 32'h5555_5555);
        add_item(depq_pkg::OP_CLEAR, 32'h0);
        add_item(depq_pkg::OP_CLEAR, 32'hFFFF_FFFF);

        // let the block fill its result path while the receiver holds off
        hold_cycles = 400;
        for (int i = 0; i < 20; i++) add_item(depq_pkg::OP_INSERT, rand_value());
        wait (pending_items.size() == 0);

        // sender pauses until everything has drained
        pause_for_drain = 1;
        wait (expected_reports.size() == 0);
        pause_for_drain = 0;

        // random: insert-heavy mix of inserts and deletes, rare clears
        n = 0;
        while (n < 1100) begin
            sel = $urandom_range(0, 99);
            if (sel < 55)      add_item(depq_pkg::OP_INSERT, rand_value());
            else if (sel < 75) add_item(depq_pkg::OP_DEL_MAX, $urandom);
            else if (sel < 97) add_item(depq_pkg::OP_DEL_MIN, $urandom);
            else               add_item(depq_pkg::OP_CLEAR, $urandom);
            n++;
        end
        wait (pending_items.size() == 0);
        wait (expected_reports.size() == 0);
        repeat (50) @(posedge i_clk);
        if (error_count == 0)
            $display("double_ended_priority_queue_core_tb: clean");
        else
            $display("double_ended_priority_queue_core_tb: errors");
        $finish;
    end

endmodule
